### rtl/psp_pkg.sv
package psp_pkg;

    // Fraction bits of the unit normal.
    localparam int NORM_FRAC = 30;
    // Default number of Newton steps on the reciprocal square root.
    localparam int RSQRT_ITER_DEF = 3;
    // Number of pipeline stages around the Newton chain.
    localparam int PRE_STAGES  = 8;
    localparam int POST_STAGES = 5;

    localparam logic [33:0] THREE_Q30 = 34'd3 << NORM_FRAC;

    // Data that rides along with the reciprocal square root.
    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][29:0]  mag;
        logic [2:0][31:0]  refp;
        logic              degen;
        logic              e;
    } t_side;

    // Seed of 1/sqrt(x) at interval midpoints, Q0.16.
    function automatic logic [15:0] seed_lookup(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd61788;
            4'd1:    v = 16'd55889;
            4'd2:    v = 16'd51410;
            4'd3:    v = 16'd47861;
            4'd4:    v = 16'd44957;
            4'd5:    v = 16'd42526;
            4'd6:    v = 16'd40450;
            4'd7:    v = 16'd38651;
            4'd8:    v = 16'd37073;
            4'd9:    v = 16'd35673;
            4'd10:   v = 16'd34422;
            default: v = 16'd33292;
        endcase
        return v;
    endfunction

endpackage

### rtl/psp_nr_cell.sv
module psp_nr_cell (
    input  logic                 i_clk,
    input  logic [2:0]           i_en,
    input  logic [31:0]          i_y,
    input  logic [31:0]          i_xq,
    input  psp_pkg::t_side       i_side,
    output logic [31:0]          o_y,
    output logic [31:0]          o_xq,
    output psp_pkg::t_side       o_side
);
    import psp_pkg::*;

    // One Newton step y = y * (3 - x*y*y) / 2 over three stages,
    // one multiplier in each.
    logic [31:0] r_y0, r_y1, r_y2;
    logic [31:0] r_x0, r_x1, r_x2;
    logic [33:0] r_t;
    logic [31:0] r_f;
    t_side       r_s0, r_s1, r_s2;

    logic [63:0] w_yy;
    logic [65:0] w_xt;
    logic [33:0] w_u;
    logic [31:0] n_f;
    logic [63:0] w_yf;

    always_comb begin
        w_yy = 64'(i_y) * 64'(i_y);
        w_xt = 66'(r_x0) * 66'(r_t);
        w_u  = w_xt[63:30];
        n_f  = (w_u >= THREE_Q30) ? 32'd0 : 32'(THREE_Q30 - w_u);
        w_yf = 64'(r_y1) * 64'(r_f);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t  <= w_yy[63:30];
            r_y0 <= i_y;
            r_x0 <= i_xq;
            r_s0 <= i_side;
        end
        if (i_en[1]) begin
            r_f  <= n_f;
            r_y1 <= r_y0;
            r_x1 <= r_x0;
            r_s1 <= r_s0;
        end
        if (i_en[2]) begin
            r_y2 <= w_yf[62:31];
            r_x2 <= r_x1;
            r_s2 <= r_s1;
        end
    end

    assign o_y    = r_y2;
    assign o_xq   = r_x2;
    assign o_side = r_s2;

endmodule

### rtl/plane_setup_from_points.sv
// Plane setup from three points, or from a normal and a point.
// Input words arrive on the s_axis channel: tuser carries the op (0 = plane
// through points A, B and C, 1 = A is the normal direction and B a point on
// the plane), and tdata carries the nine Q16.16 coordinates.
// Each result word on the m_axis channel carries the unit normal in Q1.30
// and the rounded, saturated plane offset; tuser flags a degenerate input
// whose normal has zero length, in which case all data fields are zero.
// The block is a chain of pipeline cells: eight setup stages (differences,
// cross products, magnitude, leading-one search in two steps, scaling,
// squares, sum and seed lookup), one three-stage cell per Newton step of the
// reciprocal square root, and five stages for the normal and the offset.
// One word is taken per cycle while a stalled receiver does not hold the
// chain. Every stage has its own valid bit and loads whenever it is empty
// or its successor moves, so a stalled receiver only holds the stages that
// are full; bubbles close up and input is still taken until the whole
// chain is full.
// Reset clears only the valid bits; no state carries between words.
module plane_setup_from_points #(
    parameter int RSQRT_ITERATIONS = psp_pkg::RSQRT_ITER_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each from bit 0
    input  logic [287:0]   i_s_axis_tdata,
    // op
    input  logic [0:0]     i_s_axis_tuser,
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    // normal_x, normal_y, normal_z (32 bits each), plane_offset (40 bits)
    output logic [135:0]   o_m_axis_tdata,
    // degenerate
    output logic [0:0]     o_m_axis_tuser
);
    import psp_pkg::*;

    localparam int NR0 = PRE_STAGES;
    localparam int NST = PRE_STAGES + 3 * RSQRT_ITERATIONS + POST_STAGES;
    localparam int SA  = NR0 + 3 * RSQRT_ITERATIONS;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_en;

    always_comb begin
        w_en[NST] = i_m_axis_tready;
        for (int k = NST - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_en[0];

    // Unpack the input word.
    logic signed [31:0] w_a [3];
    logic signed [31:0] w_b [3];
    logic signed [31:0] w_c [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_a[i] = i_s_axis_tdata[32*i +: 32];
            w_b[i] = i_s_axis_tdata[96 + 32*i +: 32];
            w_c[i] = i_s_axis_tdata[192 + 32*i +: 32];
        end
    end

    // Stage registers of the setup part.
    logic               r0_op;
    logic signed [32:0] r0_d [3];
    logic signed [32:0] r0_f [3];
    logic signed [31:0] r0_a [3];
    logic [31:0]        r0_ref [3];
    logic signed [65:0] r1_p [6];
    logic [31:0]        r1_ref [3];
    logic [64:0]        r2_mag [3];
    logic [2:0]         r2_neg;
    logic [31:0]        r2_ref [3];
    logic [64:0]        r3_mag [3];
    logic [2:0]         r3_neg;
    logic [31:0]        r3_ref [3];
    logic [8:0]         r3_nz;
    logic [2:0]         r3_pos [9];
    logic [64:0]        r4_mag [3];
    logic [2:0]         r4_neg;
    logic [31:0]        r4_ref [3];
    logic [6:0]         r4_len;
    t_side              r5_side;
    logic [59:0]        r6_sq [3];
    t_side              r6_side;
    logic [31:0]        r7_y;
    logic [31:0]        r7_xq;
    t_side              r7_side;

    logic signed [65:0] n1_p [6];
    logic signed [66:0] w2_diff [3];
    logic [71:0]        w3_or;
    logic [8:0]         n3_nz;
    logic [2:0]         n3_pos [9];
    logic [6:0]         n4_len;
    t_side              n5_side;
    logic [6:0]         w5_sh;
    logic [61:0]        w7_s;
    logic               w7_e;
    logic [63:0]        w7_sx;
    logic [31:0]        w7_xq;
    logic [3:0]         w7_hi;
    logic [3:0]         w7_idx;
    t_side              n7_side;

    always_comb begin
        if (r0_op) begin
            for (int i = 0; i < 3; i++) begin
                n1_p[2*i]   = 66'(r0_a[i]);
                n1_p[2*i+1] = '0;
            end
        end else begin
            n1_p[0] = r0_d[1] * r0_f[2];
            n1_p[1] = r0_d[2] * r0_f[1];
            n1_p[2] = r0_d[2] * r0_f[0];
            n1_p[3] = r0_d[0] * r0_f[2];
            n1_p[4] = r0_d[0] * r0_f[1];
            n1_p[5] = r0_d[1] * r0_f[0];
        end
        for (int i = 0; i < 3; i++) begin
            w2_diff[i] = 67'(r1_p[2*i]) - 67'(r1_p[2*i+1]);
        end
        // Leading-one search, first step: position within each byte.
        w3_or = 72'(r2_mag[0] | r2_mag[1] | r2_mag[2]);
        for (int c = 0; c < 9; c++) begin
            n3_nz[c]  = |w3_or[8*c +: 8];
            n3_pos[c] = '0;
            for (int b = 0; b < 8; b++) begin
                if (w3_or[8*c + b]) begin
                    n3_pos[c] = 3'(b);
                end
            end
        end
        // Second step: highest nonzero byte.
        n4_len = '0;
        for (int c = 0; c < 9; c++) begin
            if (r3_nz[c]) begin
                n4_len = 7'(8 * c) + 7'(r3_pos[c]) + 7'd1;
            end
        end
        // Scale so that the largest magnitude sits just below 2^30.
        n5_side.neg   = r4_neg;
        n5_side.degen = (r4_len == '0);
        n5_side.e     = 1'b0;
        w5_sh = (r4_len > 7'(NORM_FRAC)) ? r4_len - 7'(NORM_FRAC)
                                          : 7'(NORM_FRAC) - r4_len;
        for (int i = 0; i < 3; i++) begin
            n5_side.refp[i] = r4_ref[i];
            if (r4_len > 7'(NORM_FRAC)) begin
                n5_side.mag[i] = 30'(r4_mag[i] >> w5_sh);
            end else begin
                n5_side.mag[i] = 30'(r4_mag[i] << w5_sh);
            end
        end
        // Sum of squares, range reduction and seed.
        w7_s   = 62'(r6_sq[0]) + 62'(r6_sq[1]) + 62'(r6_sq[2]);
        w7_e   = (w7_s < (62'd1 << 60));
        w7_sx  = w7_e ? (64'(w7_s) << 2) : 64'(w7_s);
        w7_xq  = w7_sx[61:30];
        w7_hi  = w7_xq[31:28];
        w7_idx = (w7_hi < 4'd4) ? 4'd0 : w7_hi - 4'd4;
        n7_side   = r6_side;
        n7_side.e = w7_e;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_op <= i_s_axis_tuser[0];
            for (int i = 0; i < 3; i++) begin
                r0_d[i]   <= 33'(w_b[i]) - 33'(w_a[i]);
                r0_f[i]   <= 33'(w_c[i]) - 33'(w_a[i]);
                r0_a[i]   <= w_a[i];
                r0_ref[i] <= i_s_axis_tuser[0] ? w_b[i] : w_a[i];
            end
        end
        if (w_en[1]) begin
            r1_p   <= n1_p;
            r1_ref <= r0_ref;
        end
        if (w_en[2]) begin
            for (int i = 0; i < 3; i++) begin
                r2_neg[i] <= w2_diff[i][66];
                r2_mag[i] <= w2_diff[i][66] ? 65'(-w2_diff[i]) : 65'(w2_diff[i]);
            end
            r2_ref <= r1_ref;
        end
        if (w_en[3]) begin
            r3_mag <= r2_mag;
            r3_neg <= r2_neg;
            r3_ref <= r2_ref;
            r3_nz  <= n3_nz;
            r3_pos <= n3_pos;
        end
        if (w_en[4]) begin
            r4_mag <= r3_mag;
            r4_neg <= r3_neg;
            r4_ref <= r3_ref;
            r4_len <= n4_len;
        end
        if (w_en[5]) begin
            r5_side <= n5_side;
        end
        if (w_en[6]) begin
            for (int i = 0; i < 3; i++) begin
                r6_sq[i] <= 60'(r5_side.mag[i]) * 60'(r5_side.mag[i]);
            end
            r6_side <= r5_side;
        end
        if (w_en[7]) begin
            r7_xq   <= w7_xq;
            r7_y    <= 32'(seed_lookup((w7_idx > 4'd11) ? 4'd11 : w7_idx)) << 14;
            r7_side <= n7_side;
        end
    end

    // Chain of Newton cells.
    logic [31:0] w_ch_y  [RSQRT_ITERATIONS+1];
    logic [31:0] w_ch_xq [RSQRT_ITERATIONS+1];
    t_side       w_ch_s  [RSQRT_ITERATIONS+1];

    assign w_ch_y[0]  = r7_y;
    assign w_ch_xq[0] = r7_xq;
    assign w_ch_s[0]  = r7_side;

    for (genvar g = 0; g < RSQRT_ITERATIONS; g++) begin : g_nr
        psp_nr_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en[NR0 + 3*g +: 3]),
            .i_y    (w_ch_y[g]),
            .i_xq   (w_ch_xq[g]),
            .i_side (w_ch_s[g]),
            .o_y    (w_ch_y[g+1]),
            .o_xq   (w_ch_xq[g+1]),
            .o_side (w_ch_s[g+1])
        );
    end

    // Normal and offset stages.
    logic [62:0]        ra_qp [3];
    t_side              ra_side;
    logic signed [31:0] rb_n [3];
    t_side              rb_side;
    logic signed [63:0] rc_pr [3];
    logic               rc_degen;
    logic signed [63:0] rd_sum;
    logic               rd_degen;
    logic [135:0]       r_out_data;
    logic               r_out_degen;

    // The normal has to travel alongside the offset through the last stages.
    logic signed [31:0] rc_n [3];
    logic signed [31:0] rd_n [3];
    logic signed [31:0] rb_n_hold_x, rb_n_hold_y, rb_n_hold_z;

    logic [61:0]        wa_prod [3];
    logic [33:0]        wb_q [3];
    logic [30:0]        wb_qc [3];
    logic signed [31:0] nb_n [3];
    logic [64:0]        we_mag;
    logic [34:0]        we_sm;
    logic [39:0]        we_off;
    t_side              w_nr_side;
    logic [31:0]        w_nr_y;

    assign w_nr_side = w_ch_s[RSQRT_ITERATIONS];
    assign w_nr_y    = w_ch_y[RSQRT_ITERATIONS];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            wa_prod[i] = 62'(w_nr_side.mag[i]) * 62'(w_nr_y);
            wb_q[i]    = 34'((64'(ra_qp[i]) + (64'd1 << (NORM_FRAC - 1))) >> NORM_FRAC);
            wb_qc[i]   = (wb_q[i] > (34'd1 << NORM_FRAC)) ? (31'd1 << NORM_FRAC)
                                                            : 31'(wb_q[i]);
            if (ra_side.degen) begin
                nb_n[i] = '0;
            end else if (ra_side.neg[i]) begin
                nb_n[i] = -32'(wb_qc[i]);
            end else begin
                nb_n[i] = 32'(wb_qc[i]);
            end
        end
        we_mag = rd_sum[63] ? 65'(-rd_sum) : 65'(rd_sum);
        we_sm  = 35'((we_mag + (65'd1 << (NORM_FRAC - 1))) >> NORM_FRAC);
        if (rd_degen) begin
            we_off = '0;
        end else if (rd_sum[63]) begin
            we_off = (40'(we_sm) > (40'd1 << 39)) ? (40'd1 << 39) : -40'(we_sm);
        end else begin
            we_off = (40'(we_sm) > ((40'd1 << 39) - 40'd1)) ? ((40'd1 << 39) - 40'd1)
                                                              : 40'(we_sm);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[SA]) begin
            for (int i = 0; i < 3; i++) begin
                ra_qp[i] <= 63'(wa_prod[i]) << w_nr_side.e;
            end
            ra_side <= w_nr_side;
        end
        if (w_en[SA+1]) begin
            rb_n    <= nb_n;
            rb_side <= ra_side;
        end
        if (w_en[SA+2]) begin
            for (int i = 0; i < 3; i++) begin
                rc_pr[i] <= 64'(rb_n[i]) * 64'($signed(rb_side.refp[i]));
            end
            rc_degen <= rb_side.degen;
        end
        if (w_en[SA+3]) begin
            rd_sum   <= rc_pr[0] + rc_pr[1] + rc_pr[2];
            rd_degen <= rc_degen;
        end
        if (w_en[SA+4]) begin
            r_out_data  <= {we_off, 32'(rb_n_hold_z), 32'(rb_n_hold_y), 32'(rb_n_hold_x)};
            r_out_degen <= rd_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[SA+2]) begin
            rc_n <= rb_n;
        end
        if (w_en[SA+3]) begin
            rd_n <= rc_n;
        end
    end

    assign rb_n_hold_x = rd_n[0];
    assign rb_n_hold_y = rd_n[1];
    assign rb_n_hold_z = rd_n[2];

    assign o_m_axis_tvalid = r_vld[NST-1];
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_degen;

`ifndef SYNTHESIS
    // A degenerate result carries all-zero data.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("degenerate word with nonzero data");

    // Normal components stay within plus or minus one in Q1.30.
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[31:0])  <= 32'sd1073741824) &&
            ($signed(o_m_axis_tdata[31:0])  >= -32'sd1073741824) &&
            ($signed(o_m_axis_tdata[63:32]) <= 32'sd1073741824) &&
            ($signed(o_m_axis_tdata[63:32]) >= -32'sd1073741824) &&
            ($signed(o_m_axis_tdata[95:64]) <= 32'sd1073741824) &&
            ($signed(o_m_axis_tdata[95:64]) >= -32'sd1073741824))
        else $error("normal component out of range");

    // With the output stage empty the whole chain can move, so input is taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NST-1] |-> o_s_axis_tready)
        else $error("input stalled with an empty output stage");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int FRAC = 30;
    localparam int LATENCY = 13 + 3 * psp_pkg::RSQRT_ITER_DEF;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic OP_THREE_POINTS  = 1'b0;
    localparam logic OP_NORMAL_POINT  = 1'b1;

    typedef struct {
        logic [31:0] nx, ny, nz;
        logic [39:0] ofs;
        logic        degen;
    } plane_t;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_s_axis_tvalid;
    logic           o_s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z from bit 0
    logic [287:0]   i_s_axis_tdata;
    // op
    logic [0:0]     i_s_axis_tuser;
    logic           o_m_axis_tvalid;
    logic           i_m_axis_tready;
    // normal_x, normal_y, normal_z, plane_offset from bit 0
    logic [135:0]   o_m_axis_tdata;
    // degenerate
    logic [0:0]     o_m_axis_tuser;

    plane_setup_from_points DUT (.*);

    plane_t      planes_due[$];
    int          mismatch_count = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          degen_seen = 0;
    int          cycle_count = 0;
    int          hold_off_cycles = 0;
    bit          hold_off_go = 1'b0;
    bit          hold_off_seen = 1'b0;
    bit          sender_bursty = 1;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Magnitude helpers keep the sign apart, like the block's own datapath.
    function automatic logic [65:0] mag_of(input logic signed [65:0] v);
        return v[65] ? -v : v;
    endfunction

    // Plane prediction: exact raw normal, scale to 30 bits, Newton rsqrt.
    function automatic plane_t plane_of(input logic op, input logic [287:0] pts);
        logic signed [31:0] a [3], b [3], c [3];
        logic signed [32:0] d [3], f [3];
        logic signed [67:0] raw [3];
        logic signed [31:0] refp [3];
        logic [66:0] rmag [3];
        logic [63:0] m [3];
        logic [63:0] s, xq, y, t, u, fct, q;
        logic signed [63:0] n [3];
        logic signed [63:0] sum;
        logic [63:0] sm;
        int len, l, e, idx;
        plane_t r;
        for (int i = 0; i < 3; i++) begin
            a[i] = pts[32*i +: 32];
            b[i] = pts[96 + 32*i +: 32];
            c[i] = pts[192 + 32*i +: 32];
            d[i] = 33'(b[i]) - 33'(a[i]);
            f[i] = 33'(c[i]) - 33'(a[i]);
        end
        if (op == OP_THREE_POINTS) begin
            raw[0] = 68'(d[1]) * 68'(f[2]) - 68'(d[2]) * 68'(f[1]);
            raw[1] = 68'(d[2]) * 68'(f[0]) - 68'(d[0]) * 68'(f[2]);
            raw[2] = 68'(d[0]) * 68'(f[1]) - 68'(d[1]) * 68'(f[0]);
            for (int i = 0; i < 3; i++) refp[i] = a[i];
        end else begin
            for (int i = 0; i < 3; i++) begin
                raw[i] = 68'(a[i]);
                refp[i] = b[i];
            end
        end
        len = 0;
        for (int i = 0; i < 3; i++) begin
            rmag[i] = raw[i][67] ? 67'(-raw[i]) : 67'(raw[i]);
            l = 0;
            for (int k = 0; k < 67; k++) if (rmag[i][k]) l = k + 1;
            if (l > len) len = l;
        end
        if (len == 0) begin
            r.nx = '0; r.ny = '0; r.nz = '0; r.ofs = '0; r.degen = 1'b1;
            return r;
        end
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (len > FRAC) ? 64'(rmag[i] >> (len - FRAC))
                                : 64'(rmag[i] << (FRAC - len));
            s += m[i] * m[i];
        end
        e = (s < (64'd1 << 60)) ? 1 : 0;
        xq = (s << (2 * e)) >> FRAC;
        idx = int'(xq >> 28);
        idx = (idx < 4) ? 0 : idx - 4;
        if (idx > 11) idx = 11;
        y = 64'(psp_pkg::seed_lookup(4'(idx))) << 14;
        for (int k = 0; k < psp_pkg::RSQRT_ITER_DEF; k++) begin
            t = (y * y) >> FRAC;
            u = (xq * t) >> FRAC;
            fct = (u >= 64'(psp_pkg::THREE_Q30)) ? 64'd0 : 64'(psp_pkg::THREE_Q30) - u;
            y = (y * fct) >> (FRAC + 1);
        end
        for (int i = 0; i < 3; i++) begin
            q = (((m[i] * y) << e) + (64'd1 << (FRAC - 1))) >> FRAC;
            if (q > (64'd1 << FRAC)) q = 64'd1 << FRAC;
            n[i] = raw[i][67] ? -$signed(q) : $signed(q);
        end
        sum = n[0] * 64'(refp[0]) + n[1] * 64'(refp[1]) + n[2] * 64'(refp[2]);
        sm = ((sum < 0 ? -sum : sum) + (64'd1 << (FRAC - 1))) >> FRAC;
        if (sum < 0) begin
            if (sm > 64'd549755813888) sm = 64'd549755813888;
            r.ofs = 40'(-sm);
        end else begin
            if (sm > 64'd549755813887) sm = 64'd549755813887;
            r.ofs = 40'(sm);
        end
        r.nx = n[0][31:0]; r.ny = n[1][31:0]; r.nz = n[2][31:0];
        r.degen = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
        mismatch_count++;
    endtask

    // Sends one word; in bursty mode a random gap may come first.
    task automatic send_word(input logic op, input logic [287:0] pts);
        if (sender_bursty && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= pts;
        i_s_axis_tuser  <= op;
        planes_due.push_back(plane_of(op, pts));
        words_sent++;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic go_idle();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        go_idle();
        while (planes_due.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 2048)) - 1024);
            default: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        endcase
    endfunction

    // Result checker: one expectation per word, compared field by field.
    always @(posedge i_clk) begin
        plane_t want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (planes_due.size() == 0) begin
                report_mismatch("unexpected word", 64'(o_m_axis_tdata), 64'd0);
            end else begin
                want = planes_due.pop_front();
                if (o_m_axis_tdata[31:0] !== want.nx)
                    report_mismatch("normal_x", 64'(o_m_axis_tdata[31:0]), 64'(want.nx));
                if (o_m_axis_tdata[63:32] !== want.ny)
                    report_mismatch("normal_y", 64'(o_m_axis_tdata[63:32]), 64'(want.ny));
                if (o_m_axis_tdata[95:64] !== want.nz)
                    report_mismatch("normal_z", 64'(o_m_axis_tdata[95:64]), 64'(want.nz));
                if (o_m_axis_tdata[135:96] !== want.ofs)
                    report_mismatch("plane_offset", 64'(o_m_axis_tdata[135:96]),
                                    64'(want.ofs));
                if (o_m_axis_tuser[0] !== want.degen)
                    report_mismatch("degenerate", 64'(o_m_axis_tuser[0]), 64'(want.degen));
                if (want.degen) degen_seen++;
            end
            words_checked++;
        end
    end

    // Receiver: its own stall pattern, plus a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_off_go != hold_off_seen) begin
            hold_off_seen   <= hold_off_go;
            hold_off_cycles <= 150;
            i_m_axis_tready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else if ((cycle_count / 300) % 3 == 2) begin
            i_m_axis_tready <= 1'b1;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: timeout with %0d words outstanding", planes_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic test_directed();
        logic [287:0] p;
        // Zero normal from coincident points, and from a zero direction.
        send_word(OP_THREE_POINTS, '0);
        send_word(OP_NORMAL_POINT, {96'd0, {3{32'h0001_0000}}, 96'd0});
        // Collinear points also give a degenerate plane.
        send_word(OP_THREE_POINTS, {32'd0, 32'd0, 32'h0002_0000,
                                    32'd0, 32'd0, 32'h0001_0000, 96'd0});
        // The unit axis planes, both ops.
        send_word(OP_THREE_POINTS, {32'd0, 32'h0001_0000, 32'd0,
                                    32'd0, 32'd0, 32'h0001_0000, 96'd0});
        send_word(OP_NORMAL_POINT, {96'hFFFF_FFFF_FFFF_FFFF_FFFF_FFFF,
                                    32'h0003_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1});
        // Extreme coordinates drive the widest cross product and saturation.
        send_word(OP_THREE_POINTS, {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000});
        send_word(OP_NORMAL_POINT, {96'd0, {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}});
        send_word(OP_NORMAL_POINT, {96'd0, {3{32'h8000_0000}}, {3{32'h8000_0000}}});
        send_word(OP_NORMAL_POINT, {{3{32'hFFFF_FFFF}}, {3{32'h8000_0000}},
                                    32'd0, 32'd0, 32'h8000_0000});
        send_word(OP_NORMAL_POINT, {96'd0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
                                    32'd1, 32'd0, 32'hFFFF_FFFF});
        for (int i = 0; i < 8; i++) begin
            for (int k = 0; k < 9; k++) p[32*k +: 32] = rand_coord(i % 4);
            send_word(1'(i), p);
        end
        wait_drained();
    endtask

    task automatic test_random(input int count);
        logic [287:0] p;
        int mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 9; k++) p[32*k +: 32] = rand_coord(mode);
            // Now and then make two points equal, or zero point A, to hit degenerate planes.
            if ($urandom_range(0, 15) == 0) p[191:96] = p[95:0];
            if ($urandom_range(0, 31) == 0) p[95:0] = '0;
            send_word(1'($urandom_range(0, 1)), p);
            if (($urandom_range(0, 63) == 0)) sender_bursty = !sender_bursty;
        end
        sender_bursty = 1;
    endtask

    task automatic test_backpressure();
        logic [287:0] p;
        // The receiver holds off while words keep coming, so the chain fills.
        hold_off_go = !hold_off_go;
        sender_bursty = 0;
        for (int n = 0; n < 60; n++) begin
            for (int k = 0; k < 9; k++) p[32*k +: 32] = $urandom();
            send_word(1'($urandom_range(0, 1)), p);
        end
        sender_bursty = 1;
        wait_drained();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(380);
        test_backpressure();
        test_random(380);
        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        $display("tb: %0d words sent, %0d planes checked, %0d degenerate",
                 words_sent, words_checked, degen_seen);
        $display("tb: both ops, extreme and degenerate inputs, long receiver hold-off");
        if (mismatch_count == 0 && planes_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
